// File: design/bis_pkg.sv
// Shared constants, command and register codes for the bilinear image sampler.
`timescale 1ns / 1ps

package bis_pkg;

  // Default sizes of the pixel store and of the coordinate fraction.
  localparam int IMAGE_PIXELS_DEF = 65536;
  localparam int FRAC_BITS_DEF    = 8;

  // Fixed field widths of the ports.
  localparam int PIX_W   = 32;
  localparam int ADDR_W  = 16;
  localparam int COORD_W = 18;
  localparam int SIZE_W  = 9;
  localparam int POS_W   = SIZE_W - 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIZE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // Command codes of an input word.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Image size limits and value after reset.
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd2;
  localparam logic [SIZE_W-1:0] SIZE_MAX   = 9'd256;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // Saturation limits of the result.
  localparam logic [PIX_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [PIX_W-1:0] SAT_MIN = 32'h8000_0000;

  // Bring a programmed image size into the supported range.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] res;
    if (v < SIZE_MIN) begin
      res = SIZE_MIN;
    end else if (v > SIZE_MAX) begin
      res = SIZE_MAX;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// File: design/bilinear_image_sampler_core.sv
// A sample word passes through the registered stages below, from floor and clamp to the result register.
// Throughput: one word per cycle while the result channel is not stalled; the store is split
// into even and odd address banks, each with two read ports, so all four neighbours are fetched in the same cycle.
// Reset (synchronous, active low) empties the pipeline and sets width and height to 256.
// The pixel store is not cleared by reset; there is no clearing pass.
`timescale 1ns / 1ps

module bilinear_image_sampler_core
  import bis_pkg::*;
#(
  parameter int IMAGE_PIXELS = IMAGE_PIXELS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic        [ADDR_W-1:0]     in_pixel_addr,
  input  logic signed [PIX_W-1:0]      in_pixel_value,
  input  logic                         in_pixel_invalid,
  input  logic signed [COORD_W-1:0]    in_x_coord,
  input  logic signed [COORD_W-1:0]    in_y_coord,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [PIX_W-1:0]      out_sample_value,
  output logic                         out_sample_invalid,
  output logic                         out_sample_saturated,
  // Configuration port
  input  logic                         cfg_we,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_wdata
);

  // Pipeline shape.
  localparam int NSTG    = 10;
  localparam int STG_MEM = 4;

  // Address arithmetic and store banking.
  localparam int NA_W    = POS_W + SIZE_W;
  localparam int AW      = $clog2(IMAGE_PIXELS);
  localparam int CMP_W   = (AW + 1 > NA_W + 1) ? AW + 1 : NA_W + 1;
  localparam int BANK_D  = (IMAGE_PIXELS + 1) / 2;
  localparam int BANK_AW = $clog2(BANK_D);
  localparam int WORD_W  = PIX_W + 1;
  localparam logic [CMP_W-1:0] PIX_LIM = CMP_W'(IMAGE_PIXELS);

  // Datapath widths.
  localparam int CMAX = (COORD_W > FRAC_BITS + POS_W) ? COORD_W : FRAC_BITS + POS_W;
  localparam int P_W  = CMAX + 3;
  localparam int M_W  = P_W + PIX_W;
  localparam int R_W  = M_W + 1;
  localparam int L_W  = R_W / 2;
  localparam int RH_W = R_W - L_W;
  localparam int PL_W = P_W + L_W + 1;
  localparam int PH_W = P_W + RH_W;
  localparam int A_W  = P_W + R_W + 1;
  localparam int S_W  = A_W + 1;
  localparam int TOP  = 2 * FRAC_BITS + PIX_W - 1;

  localparam logic signed [P_W-1:0] ONE_FX = P_W'(1 << FRAC_BITS);
  localparam logic signed [S_W-1:0] RND    = S_W'(1) << (2 * FRAC_BITS - 1);

  // Floor a coordinate and clamp it to 0..size-2.
  function automatic logic [POS_W-1:0] clamp_base(input logic signed [COORD_W-1:0] c,
                                                  input logic [SIZE_W-1:0] size);
    logic signed [COORD_W-1:0] fl;
    logic        [SIZE_W-1:0]  lim;
    logic        [POS_W-1:0]   res;
    fl  = c >>> FRAC_BITS;
    lim = size - SIZE_MIN;
    if (fl < 0) begin
      res = '0;
    end else if (fl > $signed({{(COORD_W-SIZE_W){1'b0}}, lim})) begin
      res = lim[POS_W-1:0];
    end else begin
      res = fl[POS_W-1:0];
    end
    return res;
  endfunction

  // Widen a flat address for range checks and bank indexing.
  function automatic logic [CMP_W-1:0] ext_addr(input logic [NA_W-1:0] a);
    return {{(CMP_W-NA_W){1'b0}}, a};
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] image_width_r;
  logic [SIZE_W-1:0] image_height_r;

  // Register writes decoded by index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= SIZE_RESET;
      image_height_r <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valid bits and flow control
  // ---------------------------------------------------------------------------
  logic [NSTG:1]   stg_v_r;
  logic [NSTG:1]   stg_vin;
  logic [NSTG+1:1] stg_en;
  logic            s3_cmd_r;

  // A stage takes a new word when it is empty or its word moves on.
  assign stg_en[NSTG+1] = out_ready;
  for (genvar k = 1; k <= NSTG; k++) begin : g_en
    assign stg_en[k] = !stg_v_r[k] || stg_en[k+1];
  end

  // Load words leave the pipeline once they have written the store.
  always_comb begin
    stg_vin          = {stg_v_r[NSTG-1:1], in_valid};
    stg_vin[STG_MEM] = stg_v_r[STG_MEM-1] && (s3_cmd_r == CMD_SAMPLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
    end else begin
      stg_v_r <= (stg_en[NSTG:1] & stg_vin) | (~stg_en[NSTG:1] & stg_v_r);
    end
  end

  assign in_ready = stg_en[1];

  // ---------------------------------------------------------------------------
  // Stage 1: floor and clamp the coordinates
  // ---------------------------------------------------------------------------
  logic                      s1_cmd_r;
  logic [ADDR_W-1:0]         s1_addr_r;
  logic [WORD_W-1:0]         s1_word_r;
  logic signed [COORD_W-1:0] s1_x_r;
  logic signed [COORD_W-1:0] s1_y_r;
  logic [POS_W-1:0]          s1_ilow_r;
  logic [POS_W-1:0]          s1_jlow_r;
  logic [SIZE_W-1:0]         s1_w_r;
  logic [SIZE_W-1:0]         s1_w_nxt;
  logic [SIZE_W-1:0]         s1_h_nxt;

  assign s1_w_nxt = clamp_size(image_width_r);
  assign s1_h_nxt = clamp_size(image_height_r);

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      s1_cmd_r  <= in_cmd;
      s1_addr_r <= in_pixel_addr;
      s1_word_r <= {in_pixel_invalid, in_pixel_value};
      s1_x_r    <= in_x_coord;
      s1_y_r    <= in_y_coord;
      s1_ilow_r <= clamp_base(in_x_coord, s1_w_nxt);
      s1_jlow_r <= clamp_base(in_y_coord, s1_h_nxt);
      s1_w_r    <= s1_w_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: base address and fractional weights
  // ---------------------------------------------------------------------------
  logic                  s2_cmd_r;
  logic [ADDR_W-1:0]     s2_addr_r;
  logic [WORD_W-1:0]     s2_word_r;
  logic [NA_W-1:0]       s2_base_r;
  logic [SIZE_W-1:0]     s2_w_r;
  logic signed [P_W-1:0] s2_p0_r, s2_p1_r, s2_q0_r, s2_q1_r;
  logic [NA_W-1:0]       s2_prod_nxt;
  logic [NA_W-1:0]       s2_base_nxt;
  logic signed [P_W-1:0] s2_p1_nxt, s2_q1_nxt;

  assign s2_prod_nxt = s1_jlow_r * s1_w_r;
  assign s2_base_nxt = s2_prod_nxt + {{(NA_W-POS_W){1'b0}}, s1_ilow_r};

  // Fractions are taken from the clamped base, so they extrapolate off the edges.
  assign s2_p1_nxt = {{(P_W-COORD_W){s1_x_r[COORD_W-1]}}, s1_x_r}
                   - ({{(P_W-POS_W){1'b0}}, s1_ilow_r} << FRAC_BITS);
  assign s2_q1_nxt = {{(P_W-COORD_W){s1_y_r[COORD_W-1]}}, s1_y_r}
                   - ({{(P_W-POS_W){1'b0}}, s1_jlow_r} << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_addr_r <= s1_addr_r;
      s2_word_r <= s1_word_r;
      s2_base_r <= s2_base_nxt;
      s2_w_r    <= s1_w_r;
      s2_p1_r   <= s2_p1_nxt;
      s2_p0_r   <= ONE_FX - s2_p1_nxt;
      s2_q1_r   <= s2_q1_nxt;
      s2_q0_r   <= ONE_FX - s2_q1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: neighbour addresses split over the two banks
  // ---------------------------------------------------------------------------
  logic                          s3_wr_bank_r;
  logic [BANK_AW-1:0]            s3_wr_idx_r;
  logic                          s3_wr_ok_r;
  logic [WORD_W-1:0]             s3_wr_word_r;
  logic [1:0][BANK_AW-1:0]       s3_idx_even_r, s3_idx_odd_r;
  logic [1:0]                    s3_swap_r, s3_ok_lo_r, s3_ok_hi_r;
  logic signed [P_W-1:0]         s3_p0_r, s3_p1_r, s3_q0_r, s3_q1_r;
  logic [1:0][NA_W-1:0]          s3_row_nxt;
  logic [1:0][NA_W-1:0]          s3_rowp_nxt;
  logic [1:0][CMP_W-1:0]         s3_row_ext_nxt, s3_rowp_ext_nxt;
  logic [1:0][BANK_AW-1:0]       s3_idx_even_nxt, s3_idx_odd_nxt;
  logic [1:0]                    s3_swap_nxt, s3_ok_lo_nxt, s3_ok_hi_nxt;
  logic [CMP_W-1:0]              s3_wr_ext_nxt;

  // Top row starts at base, bottom row one image width further on.
  always_comb begin
    s3_row_nxt[0] = s2_base_r;
    s3_row_nxt[1] = s2_base_r + {{(NA_W-SIZE_W){1'b0}}, s2_w_r};
    for (int r = 0; r < 2; r++) begin
      s3_rowp_nxt[r]     = s3_row_nxt[r] + NA_W'(1);
      s3_row_ext_nxt[r]  = ext_addr(s3_row_nxt[r]);
      s3_rowp_ext_nxt[r] = ext_addr(s3_rowp_nxt[r]);
      s3_idx_odd_nxt[r]  = s3_row_ext_nxt[r][BANK_AW:1];
      s3_idx_even_nxt[r] = s3_rowp_ext_nxt[r][BANK_AW:1];
      s3_swap_nxt[r]     = s3_row_nxt[r][0];
      s3_ok_lo_nxt[r]    = s3_row_ext_nxt[r] < PIX_LIM;
      s3_ok_hi_nxt[r]    = s3_rowp_ext_nxt[r] < PIX_LIM;
    end
    s3_wr_ext_nxt = ext_addr(NA_W'(s2_addr_r));
  end

  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      s3_cmd_r      <= s2_cmd_r;
      s3_wr_bank_r  <= s2_addr_r[0];
      s3_wr_idx_r   <= s3_wr_ext_nxt[BANK_AW:1];
      s3_wr_ok_r    <= s3_wr_ext_nxt < PIX_LIM;
      s3_wr_word_r  <= s2_word_r;
      s3_idx_even_r <= s3_idx_even_nxt;
      s3_idx_odd_r  <= s3_idx_odd_nxt;
      s3_swap_r     <= s3_swap_nxt;
      s3_ok_lo_r    <= s3_ok_lo_nxt;
      s3_ok_hi_r    <= s3_ok_hi_nxt;
      s3_p0_r       <= s2_p0_r;
      s3_p1_r       <= s2_p1_r;
      s3_q0_r       <= s2_q0_r;
      s3_q1_r       <= s2_q1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: pixel store, even and odd address banks
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0]          mem_even_r [BANK_D];
  logic [WORD_W-1:0]          mem_odd_r  [BANK_D];
  logic [1:0][WORD_W-1:0]     s4_rd_even_r, s4_rd_odd_r;
  logic [1:0]                 s4_swap_r, s4_ok_lo_r, s4_ok_hi_r;
  logic signed [P_W-1:0]      s4_p0_r, s4_p1_r, s4_q0_r, s4_q1_r;
  logic                       s4_we_nxt;

  // Loads write at the same stage as samples read, so program order is kept.
  assign s4_we_nxt = stg_v_r[3] && stg_en[4] && (s3_cmd_r == CMD_LOAD) && s3_wr_ok_r;

  always_ff @(posedge clk) begin
    if (s4_we_nxt && !s3_wr_bank_r) begin
      mem_even_r[s3_wr_idx_r] <= s3_wr_word_r;
    end
    if (stg_en[4]) begin
      s4_rd_even_r[0] <= mem_even_r[s3_idx_even_r[0]];
      s4_rd_even_r[1] <= mem_even_r[s3_idx_even_r[1]];
    end
  end

  always_ff @(posedge clk) begin
    if (s4_we_nxt && s3_wr_bank_r) begin
      mem_odd_r[s3_wr_idx_r] <= s3_wr_word_r;
    end
    if (stg_en[4]) begin
      s4_rd_odd_r[0] <= mem_odd_r[s3_idx_odd_r[0]];
      s4_rd_odd_r[1] <= mem_odd_r[s3_idx_odd_r[1]];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      s4_swap_r  <= s3_swap_r;
      s4_ok_lo_r <= s3_ok_lo_r;
      s4_ok_hi_r <= s3_ok_hi_r;
      s4_p0_r    <= s3_p0_r;
      s4_p1_r    <= s3_p1_r;
      s4_q0_r    <= s3_q0_r;
      s4_q1_r    <= s3_q1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: order the neighbours and weight them horizontally
  // ---------------------------------------------------------------------------
  logic [1:0][WORD_W-1:0] s5_lo_nxt, s5_hi_nxt;
  logic signed [PIX_W-1:0] s5_f00, s5_f01, s5_f10, s5_f11;
  logic signed [M_W-1:0]   s5_m00_r, s5_m01_r, s5_m10_r, s5_m11_r;
  logic                    s5_bad_r;
  logic                    s5_bad_nxt;
  logic signed [P_W-1:0]   s5_q0_r, s5_q1_r;

  // An odd row address puts its left neighbour in the odd bank.
  always_comb begin
    for (int r = 0; r < 2; r++) begin
      s5_lo_nxt[r] = s4_swap_r[r] ? s4_rd_odd_r[r] : s4_rd_even_r[r];
      s5_hi_nxt[r] = s4_swap_r[r] ? s4_rd_even_r[r] : s4_rd_odd_r[r];
    end
  end

  assign s5_f00 = s5_lo_nxt[0][PIX_W-1:0];
  assign s5_f01 = s5_hi_nxt[0][PIX_W-1:0];
  assign s5_f10 = s5_lo_nxt[1][PIX_W-1:0];
  assign s5_f11 = s5_hi_nxt[1][PIX_W-1:0];

  // Missing data or an address beyond the store marks the sample invalid.
  assign s5_bad_nxt = !(&s4_ok_lo_r) || !(&s4_ok_hi_r)
                   || s5_lo_nxt[0][PIX_W] || s5_hi_nxt[0][PIX_W]
                   || s5_lo_nxt[1][PIX_W] || s5_hi_nxt[1][PIX_W];

  always_ff @(posedge clk) begin
    if (stg_en[5]) begin
      s5_m00_r <= s4_p0_r * s5_f00;
      s5_m01_r <= s4_p1_r * s5_f01;
      s5_m10_r <= s4_p0_r * s5_f10;
      s5_m11_r <= s4_p1_r * s5_f11;
      s5_bad_r <= s5_bad_nxt;
      s5_q0_r  <= s4_q0_r;
      s5_q1_r  <= s4_q1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: row sums
  // ---------------------------------------------------------------------------
  logic signed [R_W-1:0] s6_r0_r, s6_r1_r;
  logic                  s6_bad_r;
  logic signed [P_W-1:0] s6_q0_r, s6_q1_r;

  always_ff @(posedge clk) begin
    if (stg_en[6]) begin
      s6_r0_r  <= R_W'(s5_m00_r) + R_W'(s5_m01_r);
      s6_r1_r  <= R_W'(s5_m10_r) + R_W'(s5_m11_r);
      s6_bad_r <= s5_bad_r;
      s6_q0_r  <= s5_q0_r;
      s6_q1_r  <= s5_q1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: vertical weights, each row sum cut into a low and a high half
  // ---------------------------------------------------------------------------
  logic signed [PL_W-1:0] s7_pl0_r, s7_pl1_r;
  logic signed [PH_W-1:0] s7_ph0_r, s7_ph1_r;
  logic                   s7_bad_r;

  always_ff @(posedge clk) begin
    if (stg_en[7]) begin
      s7_pl0_r <= s6_q0_r * $signed({1'b0, s6_r0_r[L_W-1:0]});
      s7_ph0_r <= s6_q0_r * $signed(s6_r0_r[R_W-1:L_W]);
      s7_pl1_r <= s6_q1_r * $signed({1'b0, s6_r1_r[L_W-1:0]});
      s7_ph1_r <= s6_q1_r * $signed(s6_r1_r[R_W-1:L_W]);
      s7_bad_r <= s6_bad_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: recombine the partial products of each row
  // ---------------------------------------------------------------------------
  logic signed [A_W-1:0] s8_t0_r, s8_t1_r;
  logic                  s8_bad_r;

  always_ff @(posedge clk) begin
    if (stg_en[8]) begin
      s8_t0_r  <= (A_W'(s7_ph0_r) <<< L_W) + A_W'(s7_pl0_r);
      s8_t1_r  <= (A_W'(s7_ph1_r) <<< L_W) + A_W'(s7_pl1_r);
      s8_bad_r <= s7_bad_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9: final sum with round half up
  // ---------------------------------------------------------------------------
  logic signed [S_W-1:0] s9_acc_r;
  logic                  s9_bad_r;

  always_ff @(posedge clk) begin
    if (stg_en[9]) begin
      s9_acc_r <= S_W'(s8_t0_r) + S_W'(s8_t1_r) + RND;
      s9_bad_r <= s8_bad_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 10: drop the fraction, saturate and hold the result word
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] s10_value_r;
  logic             s10_invalid_r;
  logic             s10_sat_r;
  logic             s10_fits_nxt;
  logic [PIX_W-1:0] s10_value_nxt;

  assign s10_fits_nxt = (&s9_acc_r[S_W-1:TOP]) || !(|s9_acc_r[S_W-1:TOP]);

  always_comb begin
    if (s9_bad_r) begin
      s10_value_nxt = '0;
    end else if (s10_fits_nxt) begin
      s10_value_nxt = s9_acc_r[2*FRAC_BITS +: PIX_W];
    end else begin
      s10_value_nxt = s9_acc_r[S_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[10]) begin
      s10_value_r   <= s10_value_nxt;
      s10_invalid_r <= s9_bad_r;
      s10_sat_r     <= !s9_bad_r && !s10_fits_nxt;
    end
  end

  assign out_valid            = stg_v_r[NSTG];
  assign out_sample_value     = s10_value_r;
  assign out_sample_invalid   = s10_invalid_r;
  assign out_sample_saturated = s10_sat_r;

endmodule

// File: design/bis_checker.sv
// Port-level checks on the bilinear image sampler and the bind that attaches them.
`timescale 1ns / 1ps

module bis_checker
  import bis_pkg::*;
(
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [PIX_W-1:0]      out_sample_value,
  input logic                         out_sample_invalid,
  input logic                         out_sample_saturated
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_value)
      && $stable(out_sample_invalid) && $stable(out_sample_saturated))
    else $error("stalled result word changed");

  // An invalid sample carries a zero value and no saturation.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_invalid |-> out_sample_value == '0 && !out_sample_saturated)
    else $error("invalid sample carries data");

  // A saturated sample sits on one of the two limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_saturated
      |-> out_sample_value == SAT_MAX || out_sample_value == SAT_MIN)
    else $error("saturated sample off the limits");

  // With the output register empty the pipeline has room for a new word.
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with an empty output");

endmodule

bind bilinear_image_sampler_core bis_checker u_bis_checker (.*);
